@@ src/skset_pkg.sv @@
// ----------------------------------------------------------------------------
// skset_pkg
// Shared types and constants for the sorted key set.
// ----------------------------------------------------------------------------
package skset_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int OUT_W    = 16;

    // Operation carried in tuser.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic cmp;   // latch compare flags against the operand key
        logic ins;   // open a slot at the insert point and shift up
        logic del;   // close the slot at the match and shift down
    } t_cell_ctl;

endpackage

@@ src/skset_cell.sv @@
// ----------------------------------------------------------------------------
// skset_cell
// One slot of the sorted key chain: holds a key and its compare flags.
// ----------------------------------------------------------------------------
module skset_cell (
    input  logic                          i_clk,
    input  skset_pkg::t_cell_ctl          i_ctl,
    input  logic                          i_occ,
    input  logic [skset_pkg::KEY_W-1:0]   i_key,
    input  logic [skset_pkg::KEY_W-1:0]   i_left_key,
    input  logic [skset_pkg::KEY_W-1:0]   i_right_key,
    input  logic                          i_left_lt,
    output logic [skset_pkg::KEY_W-1:0]   o_key,
    output logic                          o_lt,
    output logic                          o_eq
);
    import skset_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             r_lt;
    logic             r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= i_occ && ($signed(r_key) < $signed(i_key));
            r_eq <= i_occ && (r_key == i_key);
        end
        // Cells below the operand keep their keys; the rest move one place.
        if (i_ctl.ins && !r_lt) begin
            r_key <= i_left_lt ? i_key : i_left_key;
        end else if (i_ctl.del && !r_lt) begin
            r_key <= i_right_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

@@ src/sorted_key_set.sv @@
// ----------------------------------------------------------------------------
// sorted_key_set
// Set of distinct signed keys kept in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// Each beat asks to insert (tuser 0) or delete (tuser 1) the key in tdata and
// returns one result beat with status, position and the new count. An item
// passes through S_CMP, in which every cell compares its key with the operand
// in parallel and registers the outcome, and S_APPLY, in which the cells shift
// toward or away from the affected slot once the result register is free. A
// new beat is taken only while idle or as S_APPLY finishes the current item.
// An insert into a full set of a key not yet present is dropped and flagged.
module sorted_key_set #(
    parameter int CAPACITY = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [skset_pkg::KEY_W-1:0]  i_s_axis_tdata,   // [31:0] key
    input  logic                         i_s_axis_tuser,   // [0] kind
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [skset_pkg::OUT_W-1:0]  o_m_axis_tdata    // [2:0] status,
                                                           // [6:3] position,
                                                           // [11:7] count
);
    import skset_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    t_state           r_state, n_state;
    logic [KEY_W-1:0] r_key;
    logic             r_kind;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;

    t_cell_ctl        ctl;
    logic             accept;
    logic             out_free;
    logic             finish;
    logic             hit;
    logic             full;
    logic [IDX_W-1:0] slot;
    t_status          status;
    logic [POS_W-1:0] pos;

    logic [KEY_W-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_occ;
    logic [CAPACITY-1:0] left_lt;
    logic [CAPACITY-1:0] boundary;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [KEY_W-1:0] left_key;
            logic [KEY_W-1:0] right_key;

            assign cell_occ[gi] = (CNT_W'(gi) < r_count);
            if (gi == 0) begin : g_first
                assign left_lt[gi]  = 1'b1;
                assign left_key     = r_key;
            end else begin : g_mid
                assign left_lt[gi]  = cell_lt[gi-1];
                assign left_key     = cell_key[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_key = r_key;
            end else begin : g_inner
                assign right_key = cell_key[gi+1];
            end
            assign boundary[gi] = left_lt[gi] && !cell_lt[gi];

            skset_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_occ       (cell_occ[gi]),
                .i_key       (r_key),
                .i_left_key  (left_key),
                .i_right_key (right_key),
                .i_left_lt   (left_lt[gi]),
                .o_key       (cell_key[gi]),
                .o_lt        (cell_lt[gi]),
                .o_eq        (cell_eq[gi])
            );
        end
    endgenerate

    // The flags form a thermometer, so the first cell not below the operand
    // is a one-hot boundary; encode it with an OR of masked indexes.
    always_comb begin
        slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            slot = slot | (IDX_W'(i) & {IDX_W{boundary[i]}});
        end
    end

    assign hit      = |cell_eq;
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign finish   = (r_state == S_APPLY) && out_free;
    assign o_s_axis_tready = (r_state == S_IDLE) || finish;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        ctl        = '0;
        status     = ST_NOT_FOUND;
        pos        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                ctl.cmp = 1'b1;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (finish) begin
                    n_state = accept ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        priority if (r_kind == KIND_INSERT && hit) begin
            status = ST_DUPLICATE;
            pos    = POS_W'(slot);
        end else if (r_kind == KIND_INSERT && full) begin
            status = ST_FULL;
        end else if (r_kind == KIND_INSERT) begin
            status  = ST_INSERTED;
            pos     = POS_W'(slot);
            ctl.ins = finish;
            if (finish) begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (hit) begin
            status  = ST_DELETED;
            pos     = POS_W'(slot);
            ctl.del = finish;
            if (finish) begin
                n_count = r_count - CNT_W'(1);
            end
        end else begin
            status = ST_NOT_FOUND;
        end

        n_out_data = {OUT_W'(0)} | OUT_W'({COUNT_W'(n_count), pos, status});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key  <= i_s_axis_tdata;
            r_kind <= i_s_axis_tuser;
        end
        if (finish) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
